### design/dttfp_pkg.sv
// Package for the decimal text to fixed-point converter.
// Holds the transaction types, character codes and the power-of-ten table.
// No dependencies.
package dttfp_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int CNT_W       = 5;
    localparam int FRAC_W      = 60;
    localparam int MAG_W       = 63;
    localparam int WIDE_W      = 68;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam logic [63:0]      POS_SAT = {1'b0, {63{1'b1}}};
    localparam logic [63:0]      NEG_SAT = {1'b1, {63{1'b0}}};

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic signed [63:0] fixed_value;
        logic               overflowed;
    } t_out;

    typedef struct packed {
        logic [MAG_W-1:0]  scaled;
        logic [FRAC_W-1:0] frac;
        logic              big;
        logic              neg;
    } t_fin;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] v;
        begin
            case (n)
                0:       v = 64'd1;
                1:       v = 64'd10;
                2:       v = 64'd100;
                3:       v = 64'd1000;
                4:       v = 64'd10000;
                5:       v = 64'd100000;
                6:       v = 64'd1000000;
                7:       v = 64'd10000000;
                8:       v = 64'd100000000;
                9:       v = 64'd1000000000;
                10:      v = 64'd10000000000;
                11:      v = 64'd100000000000;
                12:      v = 64'd1000000000000;
                13:      v = 64'd10000000000000;
                14:      v = 64'd100000000000000;
                15:      v = 64'd1000000000000000;
                16:      v = 64'd10000000000000000;
                17:      v = 64'd100000000000000000;
                18:      v = 64'd1000000000000000000;
                default: v = 64'd0;
            endcase
            return v;
        end
    endfunction

    localparam logic [63:0] SCALE = pow10(FRAC_DIGITS);

endpackage

### design/dttfp_accum.sv
// Character accumulator: parses one character per cycle into the scaled
// integer part and the padded fraction, and registers the final record,
// which stalls a last character while full. Depends on dttfp_pkg.
module dttfp_accum import dttfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_item_valid,
    input  t_in  i_item,
    output logic o_item_take,
    input  logic i_fin_take,
    output logic o_fin_valid,
    output t_fin o_fin
);

    localparam logic [CNT_W-1:0] FD_CNT = CNT_W'(FRAC_DIGITS);

    logic [MAG_W-1:0]  r_scaled, n_scaled;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_in_frac, n_in_frac;
    logic              r_neg, n_neg;
    logic              r_start, n_start;
    logic              r_big, n_big;
    logic              r_fin_valid;
    t_fin              r_fin;

    logic              fin_ready;
    logic [3:0]        digit;
    logic              is_digit;
    logic [WIDE_W-1:0] grown;
    logic [63:0]       frac_step;
    t_fin              fin_next;

    assign fin_ready   = !r_fin_valid || i_fin_take;
    assign o_item_take = i_item_valid && (!i_item.last_char || fin_ready);
    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    always_comb begin
        digit     = 4'(i_item.char_code - CH_ZERO);
        is_digit  = i_item.char_code inside {[CH_ZERO:CH_NINE]};
        grown     = (WIDE_W'(r_scaled) << 3) + (WIDE_W'(r_scaled) << 1)
                    + WIDE_W'(digit) * WIDE_W'(SCALE);
        frac_step = 64'(digit) * pow10(FRAC_DIGITS - 1 - int'(r_count));

        n_scaled  = r_scaled;
        n_frac    = r_frac;
        n_count   = r_count;
        n_in_frac = r_in_frac;
        n_neg     = r_neg;
        n_start   = r_start;
        n_big     = r_big;

        if (i_item.char_present) begin
            n_start = 1'b0;
            if (i_item.char_code == CH_MINUS) begin
                if (r_start) begin
                    n_neg = 1'b1;
                end
            end else if (i_item.char_code == CH_DOT) begin
                n_in_frac = 1'b1;
            end else if (is_digit) begin
                if (r_in_frac) begin
                    if (r_count < FD_CNT) begin
                        n_frac  = r_frac + frac_step[FRAC_W-1:0];
                        n_count = r_count + 1'b1;
                    end
                end else if (!r_big) begin
                    if (grown > WIDE_W'(MAG_MAX)) begin
                        n_big = 1'b1;
                    end else begin
                        n_scaled = grown[MAG_W-1:0];
                    end
                end
            end
        end

        fin_next.scaled = n_scaled;
        fin_next.frac   = n_frac;
        fin_next.big    = n_big;
        fin_next.neg    = n_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled    <= '0;
            r_frac      <= '0;
            r_count     <= '0;
            r_in_frac   <= 1'b0;
            r_neg       <= 1'b0;
            r_start     <= 1'b1;
            r_big       <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            if (o_item_take) begin
                if (i_item.last_char) begin
                    r_scaled  <= '0;
                    r_frac    <= '0;
                    r_count   <= '0;
                    r_in_frac <= 1'b0;
                    r_neg     <= 1'b0;
                    r_start   <= 1'b1;
                    r_big     <= 1'b0;
                end else begin
                    r_scaled  <= n_scaled;
                    r_frac    <= n_frac;
                    r_count   <= n_count;
                    r_in_frac <= n_in_frac;
                    r_neg     <= n_neg;
                    r_start   <= n_start;
                    r_big     <= n_big;
                end
            end
            if (o_item_take && i_item.last_char) begin
                r_fin_valid <= 1'b1;
            end else if (i_fin_take) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take && i_item.last_char) begin
            r_fin <= fin_next;
        end
    end

endmodule

### design/dttfp_final.sv
// Result stage: combines integer and fraction, saturates, applies the sign
// and holds the result transaction. Depends on dttfp_pkg.
module dttfp_final import dttfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fin_valid,
    input  t_fin i_fin,
    output logic o_fin_take,
    input  logic i_stall,
    output logic o_valid,
    output t_out o_data
);

    logic        r_valid;
    t_out        r_data;
    logic [63:0] sum;
    logic        ovf;
    t_out        res;

    assign o_fin_take = i_fin_valid && (!r_valid || !i_stall);
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_comb begin
        sum = {1'b0, i_fin.scaled} + 64'(i_fin.frac);
        ovf = i_fin.big || sum[63];
        res.overflowed = ovf;
        if (ovf) begin
            res.fixed_value = i_fin.neg ? NEG_SAT : POS_SAT;
        end else begin
            res.fixed_value = i_fin.neg ? (64'd0 - sum) : sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fin_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_take) begin
            r_data <= res;
        end
    end

endmodule

### design/decimal_text_to_fixed_point_core.sv
// Top level of the decimal text to fixed-point converter.
// Instantiates dttfp_accum and dttfp_final; depends on dttfp_pkg.
//
//   channel | ports                        | payload
//   --------+------------------------------+--------------------------------
//   in      | i_valid, o_stall, i_data     | char_code, char_present, last_char
//   out     | o_valid, i_stall, o_data     | fixed_value, overflowed
//
// One character per cycle while o_stall is low; the last character of a string
// passes the input register, the final record, then the result register.
// The character loop is one multiply-by-ten and add per cycle in dttfp_accum.
// Reset (sync, active low) clears control state; a new string starts after it.
// A stall on the output holds the result and backs up into o_stall only when
// a last character waits while the final record and result register are full.
module decimal_text_to_fixed_point_core import dttfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic r_in_valid;
    t_in  r_in;
    logic item_take;
    logic fin_valid;
    logic fin_take;
    t_fin fin;

    assign o_stall = r_in_valid && !item_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (item_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    dttfp_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .o_item_take  (item_take),
        .i_fin_take   (fin_take),
        .o_fin_valid  (fin_valid),
        .o_fin        (fin)
    );

    dttfp_final u_final (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_fin_take  (fin_take),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule

### dv/dttfp_conversion_checker.sv
// Checker for the decimal text to fixed-point converter: watches both channels,
// predicts each conversion from the accepted characters and compares results.
// Depends on dttfp_pkg.
module dttfp_conversion_checker import dttfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] whole_mag;
    logic [63:0] frac_kept;
    int          frac_n;
    logic        dot_seen;
    logic        neg;
    logic        fresh;
    logic        sat_seen;

    t_out pending_fixed[$];
    int   fails   = 0;
    int   checked = 0;
    int   sat_cnt = 0;

    function automatic logic [63:0] ten_pow(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) p = p * 64'd10;
        return p;
    endfunction

    task automatic clear_number();
        whole_mag = '0;
        frac_kept = '0;
        frac_n    = 0;
        dot_seen  = 1'b0;
        neg       = 1'b0;
        fresh     = 1'b1;
        sat_seen  = 1'b0;
    endtask

    task automatic fold_char(input logic [7:0] c);
        logic [63:0] d;
        logic        first;
        first = fresh;
        fresh = 1'b0;
        if (c == CH_MINUS) begin
            if (first) neg = 1'b1;
        end else if (c == CH_DOT) begin
            dot_seen = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 64'(c) - 64'(CH_ZERO);
            if (dot_seen) begin
                if (frac_n < FRAC_DIGITS) begin
                    frac_kept = frac_kept * 64'd10 + d;
                    frac_n++;
                end
            end else if (whole_mag > (POS_SAT - d) / 64'd10) begin
                whole_mag = POS_SAT;
                sat_seen  = 1'b1;
            end else begin
                whole_mag = whole_mag * 64'd10 + d;
            end
        end
    endtask

    function automatic t_out close_number();
        logic [63:0] frac;
        logic [63:0] scale;
        logic [63:0] mag;
        t_out        r;
        frac = frac_kept;
        if (frac_n < FRAC_DIGITS) frac = frac * ten_pow(FRAC_DIGITS - frac_n);
        scale = ten_pow(FRAC_DIGITS);
        r.overflowed = sat_seen || (whole_mag > (POS_SAT - frac) / scale);
        if (r.overflowed) begin
            r.fixed_value = neg ? NEG_SAT : POS_SAT;
        end else begin
            mag = whole_mag * scale + frac;
            r.fixed_value = neg ? (64'd0 - mag) : mag;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            clear_number();
            pending_fixed.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_fixed.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual value %0d overflowed %0b",
                             $time, i_out_data.fixed_value, i_out_data.overflowed);
                    fails++;
                end else begin
                    want = pending_fixed.pop_front();
                    checked++;
                    if (want.overflowed) sat_cnt++;
                    if (i_out_data.fixed_value !== want.fixed_value) begin
                        $display("%0t: fixed_value mismatch: expected %0d, actual %0d",
                                 $time, want.fixed_value, i_out_data.fixed_value);
                        fails++;
                    end
                    if (i_out_data.overflowed !== want.overflowed) begin
                        $display("%0t: overflowed mismatch: expected %0b, actual %0b",
                                 $time, want.overflowed, i_out_data.overflowed);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.char_present) fold_char(i_in_data.char_code);
                if (i_in_data.last_char) begin
                    pending_fixed.push_back(close_number());
                    clear_number();
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_fixed.size();
        o_results    <= checked;
        o_saturated  <= sat_cnt;
    end

endmodule

### dv/tb_decimal_text_to_fixed_point_core.sv
// Testbench top for decimal_text_to_fixed_point_core: drives character strings
// with random idling and stalls; dttfp_conversion_checker predicts and compares.
// Depends on dttfp_pkg, the core and the checker.
module tb_decimal_text_to_fixed_point_core;
    timeunit 1ns;
    timeprecision 1ps;
    import dttfp_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 120;
    localparam int SETTLE      = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    int fails;
    int pending;
    int results;
    int saturated;
    int cycles      = 0;
    int items_sent  = 0;
    int strings_sent = 0;
    int rx_pct      = 20;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit hold_req    = 1'b0;

    string limit_texts[4] = '{"9223372036854.775807", "9223372036854.775808",
                              "9223372036854775807", "92233720368547758070"};

    always #10 clk = ~clk;

    decimal_text_to_fixed_point_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    dttfp_conversion_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_results    (results),
        .o_saturated  (saturated)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    always begin : rx_side
        int r;
        @(posedge clk);
        if (hold_req) begin
            out_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            out_stall <= 1'b0;
            hold_req = 1'b0;
        end else if (rx_quiet) begin
            out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(8, 40)) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= (r < rx_pct);
            end
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_item(input t_in it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (it.char_present || it.last_char) items_sent++;
    endtask

    task automatic send_text(input logic [7:0] q[$], input bit end_empty);
        t_in it;
        for (int i = 0; i < q.size(); i++) begin
            if ($urandom_range(0, 19) == 0) begin
                it.char_code    = 8'($urandom_range(0, 255));
                it.char_present = 1'b0;
                it.last_char    = 1'b0;
                send_item(it);
            end
            it.char_code    = q[i];
            it.char_present = 1'b1;
            it.last_char    = !end_empty && (i == q.size() - 1);
            send_item(it);
        end
        if (end_empty || q.size() == 0) begin
            it.char_code    = 8'($urandom_range(0, 255));
            it.char_present = 1'b0;
            it.last_char    = 1'b1;
            send_item(it);
        end
        strings_sent++;
    endtask

    task automatic push_text(ref logic [7:0] q[$], input string s);
        for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
    endtask

    task automatic build_number(ref logic [7:0] q[$]);
        int r;
        int n;
        q.delete();
        if ($urandom_range(0, 1)) q.push_back(CH_MINUS);
        r = $urandom_range(0, 99);
        if (r < 10)      n = 0;
        else if (r < 80) n = $urandom_range(1, 6);
        else if (r < 92) n = $urandom_range(7, 13);
        else             n = $urandom_range(14, 22);
        repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) != 0) begin
            q.push_back(CH_DOT);
            repeat ($urandom_range(0, 9)) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic build_noise(ref logic [7:0] q[$]);
        int r;
        q.delete();
        repeat ($urandom_range(0, 12)) begin
            r = $urandom_range(0, 3);
            if (r < 2)       q.push_back(8'($urandom_range(0, 255)));
            else if (r == 2) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            else             q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_DOT);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin : stimulus
        logic [7:0] q[$];
        t_in        it;
        int         r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        it = '0;
        it.last_char = 1'b1;
        send_item(it);
        q.delete();
        push_text(q, "-0.1234567");
        send_text(q, 1'b0);
        q.delete();
        push_text(q, "8-9..5");
        send_text(q, 1'b0);
        it.char_present = 1'b1;
        it.last_char    = 1'b0;
        it.char_code    = 8'h00;
        send_item(it);
        it.char_code    = 8'hFF;
        send_item(it);
        it.char_code    = CH_NINE;
        send_item(it);
        it.char_present = 1'b0;
        it.char_code    = 8'h41;
        send_item(it);
        it.last_char    = 1'b1;
        send_item(it);
        strings_sent++;
        drain();

        hold_req = 1'b1;
        tx_quiet = 1'b1;
        for (int k = 0; k < 16; k++) begin
            q.delete();
            q.push_back(CH_ZERO + 8'(k % 10));
            send_text(q, 1'b0);
        end
        tx_quiet = 1'b0;
        drain();

        while (items_sent < ITEM_TARGET) begin
            if (strings_sent % 20 == 0) begin
                tx_quiet = ($urandom_range(0, 4) == 0);
                rx_quiet = ($urandom_range(0, 4) == 0);
                rx_pct   = $urandom_range(5, 60);
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
                q.delete();
                if ($urandom_range(0, 1)) q.push_back(CH_MINUS);
                push_text(q, limit_texts[$urandom_range(0, 3)]);
            end else if (r < 78) begin
                build_number(q);
            end else begin
                build_noise(q);
            end
            send_text(q, $urandom_range(0, 6) == 0);
            if (strings_sent % 60 == 0) drain();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d strings in %0d character transactions; %0d conversions checked, %0d saturated.",
                 strings_sent, items_sent, results, saturated);
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### decimal_text_to_fixed_point_core.f
design/dttfp_pkg.sv
design/dttfp_accum.sv
design/dttfp_final.sv
design/decimal_text_to_fixed_point_core.sv
dv/dttfp_conversion_checker.sv
dv/tb_decimal_text_to_fixed_point_core.sv
